>>> rtl/lbp_pkg.sv
// shared constants, types and the uniform-pattern lookup table for the lbp block
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = 11;
    localparam int COORD_W    = 10;
    localparam int PIX_W      = 8;
    localparam int BIN_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] RESET_LINE_WIDTH   = CNT_W'(640);
    localparam logic [CNT_W-1:0] RESET_FRAME_HEIGHT = CNT_W'(480);
    localparam logic [CNT_W-1:0] MIN_DIM            = CNT_W'(3);

    localparam logic [BIN_W-1:0] NONUNIFORM_BIN     = BIN_W'(58);
    localparam logic [PIX_W-1:0] NONUNIFORM_PATTERN = PIX_W'(58);

    typedef enum logic {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic               last;
    } t_pos;

    typedef logic [BIN_W-1:0] t_bin_lut [0:255];

    // rank of each uniform code among all uniform codes, nonuniform codes get 58
    function automatic t_bin_lut build_bin_lut();
        t_bin_lut   lut;
        logic [7:0] c;
        logic [7:0] d;
        int         rank;
        rank = 0;
        for (int i = 0; i < 256; i++) begin
            c = 8'(i);
            d = c ^ {c[6:0], c[7]};
            if ($countones(d) <= 2) begin
                lut[i] = BIN_W'(rank);
                rank   = rank + 1;
            end else begin
                lut[i] = NONUNIFORM_BIN;
            end
        end
        return lut;
    endfunction

    localparam t_bin_lut BIN_LUT = build_bin_lut();

endpackage

>>> rtl/lbp_line_buf.sv
// two line stores, one bank per line parity, read before write at the same column
module lbp_line_buf
    import lbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_bank,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [PIX_W-1:0]  i_pixel,
    output logic [PIX_W-1:0]  o_old,
    output logic [PIX_W-1:0]  o_mid
);

    logic [PIX_W-1:0] r_mem0 [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd0;
    logic [PIX_W-1:0] r_rd1;
    logic             r_bank;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_bank) begin
                r_mem0[i_addr] <= i_pixel;
            end
            r_rd0 <= r_mem0[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_bank) begin
                r_mem1[i_addr] <= i_pixel;
            end
            r_rd1 <= r_mem1[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bank <= i_bank;
        end
    end

    // the bank of this line parity holds two lines up, the other one line up
    assign o_old = r_bank ? r_rd1 : r_rd0;
    assign o_mid = r_bank ? r_rd0 : r_rd1;

endmodule

>>> rtl/lbp_window.sv
// 3x3 window shift and neighbour compares into the raw 8-bit code
module lbp_window
    import lbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_emit,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [PIX_W-1:0] i_old,
    input  logic [PIX_W-1:0] i_mid,
    input  t_pos             i_pos,
    output logic             o_valid,
    output logic [7:0]       o_code,
    output t_pos             o_pos
);

    // r_win[row*3+col], row 0 is the oldest line
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] centre;
    logic [7:0]       n_code;
    logic             r_valid;
    logic [7:0]       r_code;
    t_pos             r_pos;

    // compares against the window as it stands after this shift
    always_comb begin
        centre    = r_win[5];
        n_code[0] = i_mid    > centre;
        n_code[1] = i_pixel  > centre;
        n_code[2] = r_win[8] > centre;
        n_code[3] = r_win[7] > centre;
        n_code[4] = r_win[4] > centre;
        n_code[5] = r_win[1] > centre;
        n_code[6] = r_win[2] > centre;
        n_code[7] = i_old    > centre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= i_old;
            r_win[5] <= i_mid;
            r_win[8] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_code <= n_code;
            r_pos  <= i_pos;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_pos   = r_pos;

endmodule

>>> rtl/lbp_out_fifo.sv
// uniform mapping and a small result queue that decouples the output handshake
module lbp_out_fifo
    import lbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_code,
    input  t_pos                  i_pos,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pattern,
    output logic [BIN_W-1:0]      o_bin,
    output t_pos                  o_pos,
    output logic [FIFO_CNT_W-1:0] o_count
);

    logic [PIX_W-1:0]      r_pattern [FIFO_DEPTH];
    logic [BIN_W-1:0]      r_bin     [FIFO_DEPTH];
    t_pos                  r_pos     [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;
    logic [BIN_W-1:0]      push_bin;
    logic [PIX_W-1:0]      push_pattern;
    logic                  pop;

    always_comb begin
        push_bin     = BIN_LUT[i_code];
        push_pattern = (push_bin == NONUNIFORM_BIN) ? NONUNIFORM_PATTERN : i_code;
    end

    assign pop = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pattern[r_wr_ptr] <= push_pattern;
            r_bin[r_wr_ptr]     <= push_bin;
            r_pos[r_wr_ptr]     <= i_pos;
        end
    end

    assign o_valid   = r_count != '0;
    assign o_pattern = r_pattern[r_rd_ptr];
    assign o_bin     = r_bin[r_rd_ptr];
    assign o_pos     = r_pos[r_rd_ptr];
    assign o_count   = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !pop && r_count == FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_bin_matches_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_bin == NONUNIFORM_BIN) == (o_pattern == NONUNIFORM_PATTERN)))
        else $error("bin and pattern disagree on nonuniform code");

endmodule

>>> rtl/lbp_uniform_code_3x3.sv
// top level: config registers, raster counters, pipeline control and result queue
//
//  channel   valid        ready        payload
//  pixel in  i_valid      o_ready      i_pixel
//  result    o_valid      i_ready      o_pattern o_bin o_column o_line o_last_of_frame
//  config    i_cfg_valid  o_cfg_ready  i_cfg_index i_cfg_data
//
// one pixel per cycle sustained while results are taken; each result passes these steps
// in turn (line store read, window compare, lookup into the queue)
// o_ready drops only when in-flight items plus queued results fill the 4-entry queue
// synchronous active-low reset; line stores are not cleared, window and counters are
// config writes are always taken and act on the next pixel
module lbp_uniform_code_3x3
    import lbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pattern,
    output logic [BIN_W-1:0]   o_bin,
    output logic [COORD_W-1:0] o_column,
    output logic [COORD_W-1:0] o_line,
    output logic               o_last_of_frame,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    logic [CNT_W-1:0]      r_line_width;
    logic [CNT_W-1:0]      r_frame_height;
    logic [CNT_W-1:0]      r_x;
    logic [CNT_W-1:0]      r_y;
    logic [CNT_W-1:0]      n_x;
    logic [CNT_W-1:0]      n_y;
    logic [CNT_W:0]        x_inc;
    logic [CNT_W:0]        y_inc;
    logic                  accept;
    logic                  emit;
    logic [ADDR_W-1:0]     addr;
    t_pos                  pos;
    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic [PIX_W-1:0]      r_s1_pixel;
    t_pos                  r_s1_pos;
    logic [PIX_W-1:0]      old_pix;
    logic [PIX_W-1:0]      mid_pix;
    logic                  s2_valid;
    logic [7:0]            s2_code;
    t_pos                  s2_pos;
    t_pos                  out_pos;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [FIFO_CNT_W:0]   occupancy;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] hi);
        logic [CNT_W-1:0] r;
        r = v;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // config is stored already clamped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RESET_LINE_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH: begin
                    r_line_width <= clamp_dim(i_cfg_data, CNT_W'(MAX_WIDTH));
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= clamp_dim(i_cfg_data, CNT_W'(MAX_HEIGHT));
                end
            endcase
        end
    end

    // in-flight items plus queued results never exceed the queue depth
    assign occupancy = (FIFO_CNT_W+1)'(r_s1_valid) + (FIFO_CNT_W+1)'(s2_valid)
                     + (FIFO_CNT_W+1)'(q_count);
    assign o_ready   = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign accept    = i_valid && o_ready;

    always_comb begin
        x_inc = {1'b0, r_x} + 1'b1;
        y_inc = {1'b0, r_y} + 1'b1;
        emit  = (r_x >= CNT_W'(2)) && (r_y >= CNT_W'(2))
             && (r_x < r_line_width) && (r_y < r_frame_height);
        pos.column = COORD_W'(r_x - 1'b1);
        pos.line   = COORD_W'(r_y - 1'b1);
        pos.last   = (x_inc == {1'b0, r_line_width}) && (y_inc == {1'b0, r_frame_height});
        addr = (r_x >= CNT_W'(MAX_WIDTH)) ? ADDR_W'(MAX_WIDTH - 1) : r_x[ADDR_W-1:0];
        n_x = r_x;
        n_y = r_y;
        if (x_inc >= {1'b0, r_line_width}) begin
            n_x = '0;
            n_y = (y_inc >= {1'b0, r_frame_height}) ? '0 : y_inc[CNT_W-1:0];
        end else begin
            n_x = x_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_x <= n_x;
                r_y <= n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= emit;
            r_s1_pixel <= i_pixel;
            r_s1_pos   <= pos;
        end
    end

    lbp_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_bank  (r_y[0]),
        .i_addr  (addr),
        .i_pixel (i_pixel),
        .o_old   (old_pix),
        .o_mid   (mid_pix)
    );

    lbp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_emit  (r_s1_emit),
        .i_pixel (r_s1_pixel),
        .i_old   (old_pix),
        .i_mid   (mid_pix),
        .i_pos   (r_s1_pos),
        .o_valid (s2_valid),
        .o_code  (s2_code),
        .o_pos   (s2_pos)
    );

    lbp_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (s2_valid),
        .i_code    (s2_code),
        .i_pos     (s2_pos),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_pattern (o_pattern),
        .o_bin     (o_bin),
        .o_pos     (out_pos),
        .o_count   (q_count)
    );

    assign o_column        = out_pos.column;
    assign o_line          = out_pos.line;
    assign o_last_of_frame = out_pos.last;

    a_column_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x < CNT_W'(MAX_WIDTH))
        else $error("column counter beyond line store");

    a_line_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_y < CNT_W'(MAX_HEIGHT))
        else $error("line counter beyond frame limit");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit && pos.last) |=> (r_x == '0 && r_y == '0))
        else $error("counters did not wrap after last interior pixel");

endmodule
